>>> rtl/core/wblc_pkg.sv
// Package for the window blind and lamp controller.
// Holds shared types, codes and constants; no dependencies.
package wblc_pkg;

   // Event kinds carried in the request tuser
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_LIGHT = 2'd1,
      ACT_BYTE  = 2'd2,
      ACT_TOUCH = 2'd3
   } action_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOUR_MODULUS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MORNING_HOUR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_HOUR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_HOURS       = 3'd4;
   localparam int CSR_DATA_W = 12;

   // Register reset values
   localparam logic [7:0]  RST_HOUR_MODULUS    = 8'd24;
   localparam logic [7:0]  RST_MORNING_HOUR    = 8'd6;
   localparam logic [7:0]  RST_NIGHT_HOUR      = 8'd18;
   localparam logic [11:0] RST_LIGHT_THRESHOLD = 12'd2000;
   localparam logic [7:0]  RST_RUN_HOURS       = 8'd4;

   // Touch column window
   localparam logic [9:0] COL_LOW  = 10'd116;
   localparam logic [9:0] COL_HIGH = 10'd252;

   // Serial line characters
   localparam logic [7:0] CH_LAMP  = 8'h4C;
   localparam logic [7:0] CH_BLIND = 8'h42;
   localparam logic [7:0] CH_MODE  = 8'h4D;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // Beat widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [7:0]  hour_modulus;
      logic [7:0]  morning_hour;
      logic [7:0]  night_hour;
      logic [11:0] light_threshold;
      logic [7:0]  run_hours;
   } cfg_type;

endpackage

>>> rtl/core/wblc_csr.sv
// Configuration registers of the blind and lamp controller.
// Uses wblc_pkg for register indexes, reset values and cfg_type.
module wblc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wblc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wblc_pkg::CSR_DATA_W-1:0]  csr_data,
   output wblc_pkg::cfg_type                cfg
);

   wblc_pkg::cfg_type cfg_ff;
   wblc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode one write beat; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            wblc_pkg::CSR_HOUR_MODULUS:    cfg_in.hour_modulus    = csr_data[7:0];
            wblc_pkg::CSR_MORNING_HOUR:    cfg_in.morning_hour    = csr_data[7:0];
            wblc_pkg::CSR_NIGHT_HOUR:      cfg_in.night_hour      = csr_data[7:0];
            wblc_pkg::CSR_LIGHT_THRESHOLD: cfg_in.light_threshold = csr_data[11:0];
            wblc_pkg::CSR_RUN_HOURS:       cfg_in.run_hours       = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hour_modulus    <= wblc_pkg::RST_HOUR_MODULUS;
         cfg_ff.morning_hour    <= wblc_pkg::RST_MORNING_HOUR;
         cfg_ff.night_hour      <= wblc_pkg::RST_NIGHT_HOUR;
         cfg_ff.light_threshold <= wblc_pkg::RST_LIGHT_THRESHOLD;
         cfg_ff.run_hours       <= wblc_pkg::RST_RUN_HOURS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/wblc_event.sv
// Event handler: controller state and its single-pass update per beat.
// Uses wblc_pkg for codes, constants and cfg_type.
module wblc_event #(
   parameter int ROW_HEIGHT = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        action,
   input  logic [11:0]                       light_sample,
   input  logic [7:0]                        rx_byte,
   input  logic [9:0]                        touch_x,
   input  logic [9:0]                        touch_y,
   input  wblc_pkg::cfg_type                 cfg,
   output logic [wblc_pkg::RSP_DATA_W-1:0]   rsp_data
);

   // touch row bounds, one bit wider than the row coordinate
   localparam logic [10:0] ROW3_LO = 11'(3 * ROW_HEIGHT);
   localparam logic [10:0] ROW4_LO = 11'(4 * ROW_HEIGHT);
   localparam logic [10:0] ROW5_LO = 11'(5 * ROW_HEIGHT);
   localparam logic [10:0] ROW6_LO = 11'(6 * ROW_HEIGHT);

   logic [7:0]  hour_count_ff, hour_count_in;
   logic [7:0]  stop_hour_ff, stop_hour_in;
   logic [11:0] last_light_ff, last_light_in;
   logic        auto_flag_ff, auto_flag_in;
   logic        blind_up_ff, blind_up_in;
   logic        lamp_flag_ff, lamp_flag_in;
   logic        raise_line_ff, raise_line_in;
   logic        lower_line_ff, lower_line_in;
   logic        busy_flag_ff, busy_flag_in;
   logic [7:0]  line_head_ff, line_head_in;
   logic        line_open_ff, line_open_in;

   // stop hour: hour plus run length, folded once at the modulus
   function automatic logic [7:0] arm_stop(input logic [7:0] hour,
                                           input logic [7:0] run,
                                           input logic [7:0] modulus);
      logic [8:0] sum;
      sum = {1'b0, hour} + {1'b0, run};
      if (sum >= {1'b0, modulus})
         sum = sum - {1'b0, modulus};
      return sum[7:0];
   endfunction

   // next state for the beat on the input
   always_comb begin
      logic [8:0]  tick_sum;
      logic [7:0]  head_eff;
      logic [10:0] row_y;
      logic        in_cols;

      hour_count_in = hour_count_ff;
      stop_hour_in  = stop_hour_ff;
      last_light_in = last_light_ff;
      auto_flag_in  = auto_flag_ff;
      blind_up_in   = blind_up_ff;
      lamp_flag_in  = lamp_flag_ff;
      raise_line_in = raise_line_ff;
      lower_line_in = lower_line_ff;
      busy_flag_in  = busy_flag_ff;
      line_head_in  = line_head_ff;
      line_open_in  = line_open_ff;

      tick_sum = {1'b0, hour_count_ff} + 9'd1;
      head_eff = line_open_ff ? line_head_ff : rx_byte;
      row_y    = {1'b0, touch_y};
      in_cols  = (touch_x >= wblc_pkg::COL_LOW) && (touch_x <= wblc_pkg::COL_HIGH);

      unique case (wblc_pkg::action_type'(action))
         wblc_pkg::ACT_TICK: begin
            hour_count_in = (tick_sum >= {1'b0, cfg.hour_modulus}) ? 8'd0 : tick_sum[7:0];
            // scheduled moves in auto mode
            if (auto_flag_ff && !busy_flag_ff) begin
               if (hour_count_in == cfg.morning_hour) begin
                  if (!blind_up_ff) begin
                     raise_line_in = 1'b1;
                     blind_up_in   = 1'b1;
                     busy_flag_in  = 1'b1;
                  end
                  stop_hour_in = arm_stop(hour_count_in, cfg.run_hours, cfg.hour_modulus);
               end else if (hour_count_in == cfg.night_hour) begin
                  if (blind_up_ff) begin
                     lower_line_in = 1'b1;
                     blind_up_in   = 1'b0;
                     busy_flag_in  = 1'b1;
                  end
                  stop_hour_in = arm_stop(hour_count_in, cfg.run_hours, cfg.hour_modulus);
               end
            end
            // end of a timed move: release the current direction only
            if (busy_flag_in && (hour_count_in == stop_hour_in)) begin
               if (!blind_up_in)
                  lower_line_in = 1'b0;
               else
                  raise_line_in = 1'b0;
               busy_flag_in = 1'b0;
            end
            if (auto_flag_ff)
               lamp_flag_in = blind_up_in;
         end

         wblc_pkg::ACT_LIGHT: begin
            last_light_in = light_sample;
            if (auto_flag_ff && !busy_flag_ff) begin
               if ((light_sample < cfg.light_threshold) &&
                   (hour_count_ff < cfg.morning_hour)) begin
                  if (!blind_up_ff) begin
                     raise_line_in = 1'b1;
                     blind_up_in   = 1'b1;
                     busy_flag_in  = 1'b1;
                     stop_hour_in  = arm_stop(hour_count_ff, cfg.run_hours,
                                              cfg.hour_modulus);
                  end
               end else if ((light_sample >= cfg.light_threshold) &&
                            (hour_count_ff < cfg.night_hour)) begin
                  if (blind_up_ff) begin
                     lower_line_in = 1'b1;
                     blind_up_in   = 1'b0;
                     busy_flag_in  = 1'b1;
                     stop_hour_in  = arm_stop(hour_count_ff, cfg.run_hours,
                                              cfg.hour_modulus);
                  end
               end
            end
         end

         wblc_pkg::ACT_BYTE: begin
            // keep the first byte of a line
            if (!line_open_ff) begin
               line_head_in = rx_byte;
               line_open_in = 1'b1;
            end
            // newline acts on the line's first byte
            if (rx_byte == wblc_pkg::CH_NL) begin
               if ((head_eff == wblc_pkg::CH_LAMP) && !auto_flag_ff) begin
                  lamp_flag_in = !lamp_flag_ff;
               end else if ((head_eff == wblc_pkg::CH_BLIND) && !auto_flag_ff) begin
                  if (!blind_up_ff) begin
                     raise_line_in = 1'b1;
                     blind_up_in   = 1'b1;
                  end else begin
                     lower_line_in = 1'b1;
                     blind_up_in   = 1'b0;
                  end
                  busy_flag_in = 1'b1;
                  stop_hour_in = arm_stop(hour_count_ff, cfg.run_hours, cfg.hour_modulus);
               end else if (head_eff == wblc_pkg::CH_MODE) begin
                  auto_flag_in = !auto_flag_ff;
               end
               line_open_in = 1'b0;
            end
         end

         wblc_pkg::ACT_TOUCH: begin
            if (in_cols) begin
               // blind row: manual and idle motor only
               if ((row_y >= ROW4_LO) && (row_y < ROW5_LO) &&
                   !busy_flag_ff && !auto_flag_ff) begin
                  if (!blind_up_ff) begin
                     raise_line_in = 1'b1;
                     blind_up_in   = 1'b1;
                  end else begin
                     lower_line_in = 1'b1;
                     blind_up_in   = 1'b0;
                  end
                  busy_flag_in = 1'b1;
                  stop_hour_in = arm_stop(hour_count_ff, cfg.run_hours, cfg.hour_modulus);
               end
               // lamp row: manual only
               if ((row_y >= ROW5_LO) && (row_y < ROW6_LO) && !auto_flag_ff)
                  lamp_flag_in = !lamp_flag_ff;
               // mode row
               if ((row_y >= ROW3_LO) && (row_y < ROW4_LO))
                  auto_flag_in = !auto_flag_ff;
            end
         end

         default: ;
      endcase
   end

   // result beat is the state after the event
   assign rsp_data = {6'd0, busy_flag_in, lower_line_in, raise_line_in, lamp_flag_in,
                      blind_up_in, auto_flag_in, last_light_in, hour_count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_count_ff <= '0;
         stop_hour_ff  <= '0;
         last_light_ff <= '0;
         auto_flag_ff  <= 1'b0;
         blind_up_ff   <= 1'b0;
         lamp_flag_ff  <= 1'b0;
         raise_line_ff <= 1'b0;
         lower_line_ff <= 1'b0;
         busy_flag_ff  <= 1'b0;
         line_head_ff  <= '0;
         line_open_ff  <= 1'b0;
      end else if (accept) begin
         hour_count_ff <= hour_count_in;
         stop_hour_ff  <= stop_hour_in;
         last_light_ff <= last_light_in;
         auto_flag_ff  <= auto_flag_in;
         blind_up_ff   <= blind_up_in;
         lamp_flag_ff  <= lamp_flag_in;
         raise_line_ff <= raise_line_in;
         lower_line_ff <= lower_line_in;
         busy_flag_ff  <= busy_flag_in;
         line_head_ff  <= line_head_in;
         line_open_ff  <= line_open_in;
      end
   end

endmodule

>>> rtl/core/wblc_skid.sv
// Two-entry result buffer: output register plus skid register.
// Uses wblc_pkg for the result beat width.
module wblc_skid (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [wblc_pkg::RSP_DATA_W-1:0]   in_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [wblc_pkg::RSP_DATA_W-1:0]   out_data
);

   logic                            out_valid_ff, out_valid_in;
   logic [wblc_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic [wblc_pkg::RSP_DATA_W-1:0] skid_data_ff, skid_data_in;
   logic                            push;
   logic                            pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;

   // skid only fills while the output register is held
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = in_data;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> rtl/core/window_blind_lamp_controller.sv
// Top level of the blind and lamp controller.
// Instantiates wblc_csr, wblc_event and wblc_skid; uses wblc_pkg.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tdata 40 bit, tuser 2 bit
//   rsp      out        rsp_tvalid/rsp_tready   tdata 32 bit
//   csr      in         csr_valid/csr_ready     csr_index 3 bit, csr_data 12 bit
//
// One event per cycle unless stalled; the state update is a single pass
// of compare and add logic. Each result beat is registered in the output
// register, or in the skid register while the output register is held;
// requests stall only when both hold beats. csr_ready is always high.
// Reset is synchronous: state cleared, registers to their defaults.
module window_blind_lamp_controller #(
   parameter int ROW_HEIGHT = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: light_sample[11:0], rx_byte[19:12], touch_x[29:20], touch_y[39:30]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wblc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request user: action[1:0]
   input  logic [wblc_pkg::REQ_USER_W-1:0]   req_tuser,
   // result: hour_now[7:0], light_seen[19:8], auto_on[20], blind_raised[21],
   // lamp_on[22], raise_drive[23], lower_drive[24], motor_busy[25], zero[31:26]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wblc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wblc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wblc_pkg::CSR_DATA_W-1:0]   csr_data
);

   wblc_pkg::cfg_type               cfg;
   logic [wblc_pkg::RSP_DATA_W-1:0] evt_data;
   logic                            accept;

   assign accept = req_tvalid && req_tready;

   wblc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wblc_event #(
      .ROW_HEIGHT (ROW_HEIGHT)
   ) u_event (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_tuser[1:0]),
      .light_sample (req_tdata[11:0]),
      .rx_byte      (req_tdata[19:12]),
      .touch_x      (req_tdata[29:20]),
      .touch_y      (req_tdata[39:30]),
      .cfg          (cfg),
      .rsp_data     (evt_data)
   );

   wblc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (evt_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

>>> dv/window_blind_lamp_controller_tb.sv
// Self-checking testbench for window_blind_lamp_controller.
// Depends on wblc_pkg and the controller RTL only; drives its three
// channels with directed and random events and checks every result beat.
`timescale 1ns / 1ps

module window_blind_lamp_controller_tb;

   localparam int ROW_H = 32;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Expected controller status after one event
   typedef struct {
      logic [7:0]  hour_now;
      logic [11:0] light_seen;
      logic        auto_on;
      logic        blind_raised;
      logic        lamp_on;
      logic        raise_drive;
      logic        lower_drive;
      logic        motor_busy;
   } panel_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [wblc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [wblc_pkg::REQ_USER_W-1:0] req_tuser = wblc_pkg::ACT_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [wblc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [wblc_pkg::CSR_IDX_W-1:0] csr_index = wblc_pkg::CSR_HOUR_MODULUS;
   logic [wblc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Register shadow, as seen by the block
   wblc_pkg::cfg_type cfg = '{hour_modulus: wblc_pkg::RST_HOUR_MODULUS,
                              morning_hour: wblc_pkg::RST_MORNING_HOUR,
                              night_hour: wblc_pkg::RST_NIGHT_HOUR,
                              light_threshold: wblc_pkg::RST_LIGHT_THRESHOLD,
                              run_hours: wblc_pkg::RST_RUN_HOURS};

   // Predicted controller state
   logic [7:0]  hr_count = '0;
   logic [7:0]  move_end_hr = '0;
   logic [11:0] light_last = '0;
   logic [7:0]  cmd_first = '0;
   bit auto_mode, blind_up, lamp_lit, up_line, down_line, motor_timing, cmd_pending;

   panel_status_type panel_status_q[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   // Idling controls: the sender reads req_idle_on, the receiver the rest at the falling edge
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_left = 0;
   int stall_left = 0;

   window_blind_lamp_controller #(.ROW_HEIGHT(ROW_H)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Mostly no gap, sometimes a short one, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 35);
   endfunction

   // ---------------- status predictor ----------------

   function automatic void arm_move_end();
      int unsigned t;
      t = hr_count + cfg.run_hours;
      if (t >= cfg.hour_modulus) t = t - cfg.hour_modulus;
      move_end_hr = 8'(t);
   endfunction

   function automatic void raise_blind();
      if (!blind_up) begin
         up_line = 1'b1;
         blind_up = 1'b1;
         motor_timing = 1'b1;
      end
   endfunction

   function automatic void lower_blind();
      if (blind_up) begin
         down_line = 1'b1;
         blind_up = 1'b0;
         motor_timing = 1'b1;
      end
   endfunction

   // Manual blind toggle; re-arms the stop hour even mid-move
   function automatic void flip_blind();
      if (auto_mode) return;
      if (!blind_up) raise_blind();
      else lower_blind();
      arm_move_end();
   endfunction

   function automatic void flip_lamp();
      if (!auto_mode) lamp_lit = !lamp_lit;
   endfunction

   function automatic panel_status_type next_panel_status(wblc_pkg::action_type act,
                                                           logic [11:0] lv,
                                                           logic [7:0] rx, logic [9:0] tx,
                                                           logic [9:0] ty);
      panel_status_type s;
      int unsigned nxt;
      case (act)
         wblc_pkg::ACT_TICK: begin
            nxt = hr_count + 1;
            hr_count = (nxt >= cfg.hour_modulus) ? 8'd0 : 8'(nxt);
            if (auto_mode && !motor_timing) begin
               if (hr_count == cfg.morning_hour) begin
                  raise_blind();
                  arm_move_end();
               end else if (hr_count == cfg.night_hour) begin
                  lower_blind();
                  arm_move_end();
               end
            end
            // stop only releases the line of the current direction
            if (motor_timing && hr_count == move_end_hr) begin
               if (!blind_up) down_line = 1'b0;
               else up_line = 1'b0;
               motor_timing = 1'b0;
            end
            if (auto_mode) lamp_lit = blind_up;
         end
         wblc_pkg::ACT_LIGHT: begin
            light_last = lv;
            if (auto_mode && !motor_timing) begin
               if (lv < cfg.light_threshold && hr_count < cfg.morning_hour) begin
                  if (!blind_up) begin
                     raise_blind();
                     arm_move_end();
                  end
               end else if (lv >= cfg.light_threshold && hr_count < cfg.night_hour) begin
                  if (blind_up) begin
                     lower_blind();
                     arm_move_end();
                  end
               end
            end
         end
         wblc_pkg::ACT_BYTE: begin
            // only the first byte of a line matters; newline acts on it
            if (!cmd_pending) begin
               cmd_first = rx;
               cmd_pending = 1'b1;
            end
            if (rx == wblc_pkg::CH_NL) begin
               if (cmd_first == wblc_pkg::CH_LAMP && !auto_mode) flip_lamp();
               else if (cmd_first == wblc_pkg::CH_BLIND && !auto_mode) flip_blind();
               else if (cmd_first == wblc_pkg::CH_MODE) auto_mode = !auto_mode;
               cmd_pending = 1'b0;
            end
         end
         default: begin
            if (tx >= wblc_pkg::COL_LOW && tx <= wblc_pkg::COL_HIGH) begin
               if (ty >= 4 * ROW_H && ty < 5 * ROW_H && !motor_timing) flip_blind();
               if (ty >= 5 * ROW_H && ty < 6 * ROW_H) flip_lamp();
               if (ty >= 3 * ROW_H && ty < 4 * ROW_H) auto_mode = !auto_mode;
            end
         end
      endcase
      s.hour_now = hr_count;
      s.light_seen = light_last;
      s.auto_on = auto_mode;
      s.blind_raised = blind_up;
      s.lamp_on = lamp_lit;
      s.raise_drive = up_line;
      s.lower_drive = down_line;
      s.motor_busy = motor_timing;
      return s;
   endfunction

   // ---------------- channel drivers ----------------

   // Send one event; fields the action does not use carry random junk
   task automatic send_event(wblc_pkg::action_type act, int unsigned a, int unsigned b);
      logic [11:0] lv;
      logic [7:0] rx;
      logic [9:0] tx, ty;
      int idle;
      lv = (act == wblc_pkg::ACT_LIGHT) ? 12'(a) : 12'($urandom);
      rx = (act == wblc_pkg::ACT_BYTE) ? 8'(a) : 8'($urandom);
      tx = (act == wblc_pkg::ACT_TOUCH) ? 10'(a) : 10'($urandom);
      ty = (act == wblc_pkg::ACT_TOUCH) ? 10'(b) : 10'($urandom);
      idle = req_idle_on ? pick_gap() : 0;
      repeat (idle) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {ty, tx, rx, lv};
      req_tuser <= act;
      do @(posedge clock); while (!req_tready);
      panel_status_q.push_back(next_panel_status(act, lv, rx, tx, ty));
   endtask

   // Stop sending and wait for every expected beat, plus the pipeline depth
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (panel_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [wblc_pkg::CSR_IDX_W-1:0] idx,
                            logic [wblc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         wblc_pkg::CSR_HOUR_MODULUS:    cfg.hour_modulus = val[7:0];
         wblc_pkg::CSR_MORNING_HOUR:    cfg.morning_hour = val[7:0];
         wblc_pkg::CSR_NIGHT_HOUR:      cfg.night_hour = val[7:0];
         wblc_pkg::CSR_LIGHT_THRESHOLD: cfg.light_threshold = val;
         wblc_pkg::CSR_RUN_HOURS:       cfg.run_hours = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(int unsigned modulus, int unsigned morning, int unsigned night,
                               int unsigned threshold, int unsigned run);
      settle();
      write_reg(wblc_pkg::CSR_HOUR_MODULUS, wblc_pkg::CSR_DATA_W'(modulus));
      write_reg(wblc_pkg::CSR_MORNING_HOUR, wblc_pkg::CSR_DATA_W'(morning));
      write_reg(wblc_pkg::CSR_NIGHT_HOUR, wblc_pkg::CSR_DATA_W'(night));
      write_reg(wblc_pkg::CSR_LIGHT_THRESHOLD, wblc_pkg::CSR_DATA_W'(threshold));
      write_reg(wblc_pkg::CSR_RUN_HOURS, wblc_pkg::CSR_DATA_W'(run));
   endtask

   // One random event, or a whole serial line; returns beats sent
   task automatic send_random_event(output int unsigned beats);
      int unsigned pick, r, filler, lo, hi, x, y;
      logic [7:0] head;
      beats = 1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_event(wblc_pkg::ACT_TICK, 0, 0);
      end else if (pick < 60) begin
         // half the samples sit around the threshold
         if ($urandom_range(0, 1)) begin
            lo = (cfg.light_threshold < 2) ? 0 : cfg.light_threshold - 2;
            hi = (cfg.light_threshold > 4093) ? 4095 : cfg.light_threshold + 2;
            send_event(wblc_pkg::ACT_LIGHT, $urandom_range(lo, hi), 0);
         end else begin
            send_event(wblc_pkg::ACT_LIGHT, $urandom_range(0, 4095), 0);
         end
      end else if (pick < 80) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            send_event(wblc_pkg::ACT_BYTE, $urandom_range(0, 255), 0);
         end else begin
            case ($urandom_range(0, 3))
               0: head = wblc_pkg::CH_LAMP;
               1: head = wblc_pkg::CH_BLIND;
               2: head = wblc_pkg::CH_MODE;
               default: head = 8'($urandom);
            endcase
            filler = $urandom_range(0, 2);
            send_event(wblc_pkg::ACT_BYTE, head, 0);
            repeat (filler) send_event(wblc_pkg::ACT_BYTE, $urandom_range(0, 255), 0);
            send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_NL, 0);
            beats = filler + 2;
         end
      end else begin
         r = $urandom_range(0, 9);
         y = $urandom_range(3 * ROW_H, 6 * ROW_H - 1);
         if (r < 6) begin
            x = $urandom_range(wblc_pkg::COL_LOW, wblc_pkg::COL_HIGH);
         end else if (r < 8) begin
            case ($urandom_range(0, 3))
               0: x = wblc_pkg::COL_LOW - 1;
               1: x = wblc_pkg::COL_LOW;
               2: x = wblc_pkg::COL_HIGH;
               default: x = wblc_pkg::COL_HIGH + 1;
            endcase
         end else begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
         end
         send_event(wblc_pkg::ACT_TOUCH, x, y);
      end
   endtask

   task automatic run_random(int unsigned count);
      int unsigned sent, got;
      sent = 0;
      while (sent < count) begin
         send_random_event(got);
         sent += got;
      end
   endtask

   // ---------------- receiver and result check ----------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_idle_on) stall_left = pick_gap();
      end
   end

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      panel_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (panel_status_q.size() == 0) begin
            $error("result beat %h with nothing expected", rsp_tdata);
            fail_count++;
         end else begin
            want = panel_status_q.pop_front();
            compare_field("hour_now", want.hour_now, rsp_tdata[7:0]);
            compare_field("light_seen", want.light_seen, rsp_tdata[19:8]);
            compare_field("auto_on", want.auto_on, rsp_tdata[20]);
            compare_field("blind_raised", want.blind_raised, rsp_tdata[21]);
            compare_field("lamp_on", want.lamp_on, rsp_tdata[22]);
            compare_field("raise_drive", want.raise_drive, rsp_tdata[23]);
            compare_field("lower_drive", want.lower_drive, rsp_tdata[24]);
            compare_field("motor_busy", want.motor_busy, rsp_tdata[25]);
            compare_field("padding", 0, rsp_tdata[31:26]);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- tests ----------------

   // Column window edges and every touch row, in manual mode
   task automatic test_touch_rows();
      send_event(wblc_pkg::ACT_TOUCH, wblc_pkg::COL_LOW - 1, 4 * ROW_H);
      send_event(wblc_pkg::ACT_TOUCH, wblc_pkg::COL_LOW, 4 * ROW_H);   // blind up, move starts
      send_event(wblc_pkg::ACT_TOUCH, wblc_pkg::COL_HIGH, 5 * ROW_H);  // lamp on
      send_event(wblc_pkg::ACT_TOUCH, wblc_pkg::COL_HIGH + 1, 5 * ROW_H);
      send_event(wblc_pkg::ACT_TOUCH, 1023, 1023);
      send_event(wblc_pkg::ACT_TOUCH, 0, 0);
      send_event(wblc_pkg::ACT_TOUCH, 200, 6 * ROW_H - 1);      // lamp off
      send_event(wblc_pkg::ACT_TOUCH, 200, 6 * ROW_H);
      send_event(wblc_pkg::ACT_TOUCH, 200, 4 * ROW_H - 1);      // auto on
      send_event(wblc_pkg::ACT_TOUCH, 200, 3 * ROW_H);          // auto off
   endtask

   // Lamp, blind and mode lines, a lone newline and junk bytes
   task automatic test_serial_commands();
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_LAMP, 0);
      send_event(wblc_pkg::ACT_BYTE, 8'h78, 0);
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_NL, 0);
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_NL, 0);
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_BLIND, 0);    // reversal while busy
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_NL, 0);
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_MODE, 0);
      send_event(wblc_pkg::ACT_BYTE, 8'hFF, 0);
      send_event(wblc_pkg::ACT_BYTE, 8'h00, 0);
      send_event(wblc_pkg::ACT_BYTE, wblc_pkg::CH_NL, 0);
   endtask

   // Light extremes and ticks through the end of a move, in auto mode
   task automatic test_light_and_ticks();
      send_event(wblc_pkg::ACT_LIGHT, 4095, 0);
      send_event(wblc_pkg::ACT_LIGHT, 0, 0);
      repeat (5) send_event(wblc_pkg::ACT_TICK, 0, 0);
      send_event(wblc_pkg::ACT_LIGHT, wblc_pkg::RST_LIGHT_THRESHOLD - 1, 0);
      send_event(wblc_pkg::ACT_LIGHT, wblc_pkg::RST_LIGHT_THRESHOLD, 0);
   endtask

   task automatic test_default_day();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(50);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_random(100);
   endtask

   task automatic test_low_extremes();
      apply_config(1, 0, 0, 0, 1);
      run_random(120);
   endtask

   task automatic test_high_extremes();
      apply_config(255, 255, 255, 4095, 255);
      run_random(120);
   endtask

   // Receiver holds off while the sender keeps offering, then a full drain
   task automatic test_short_day_backpressure();
      apply_config(8, 2, 5, 2048, 2);
      run_random(60);
      hold_left = 90;
      req_idle_on = 1'b0;
      run_random(30);
      req_idle_on = 1'b1;
      settle();
      run_random(60);
   endtask

   task automatic test_random_settings();
      int unsigned modulus;
      repeat (3) begin
         modulus = $urandom_range(2, 40);
         apply_config(modulus, $urandom_range(0, modulus - 1), $urandom_range(0, modulus - 1),
                      $urandom_range(0, 4095), $urandom_range(1, modulus));
         run_random(120);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_touch_rows();
      test_serial_commands();
      test_light_and_ticks();
      test_default_day();
      test_low_extremes();
      test_high_extremes();
      test_short_day_backpressure();
      test_random_settings();
      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && panel_status_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/wblc_pkg.sv
rtl/core/wblc_csr.sv
rtl/core/wblc_event.sv
rtl/core/wblc_skid.sv
rtl/core/window_blind_lamp_controller.sv
dv/window_blind_lamp_controller_tb.sv
